FILE: sv/smf_pkg.sv
// Shared types and constants of the sliding median filter.
// Depends on nothing; every other file imports it.
package smf_pkg;

	localparam int WINDOW_MAX  = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int LEN_BITS    = 5;
	localparam int COUNT_BITS  = $clog2(WINDOW_MAX + 1);
	localparam int AGE_BITS    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int IDX_BITS    = AGE_BITS;
	localparam int LEN_RESET   = 16;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]         count_t;
	typedef logic [AGE_BITS-1:0]           age_t;
	typedef logic [IDX_BITS-1:0]           idx_t;
	typedef logic [LEN_BITS-1:0]           len_t;

	// What one cell shows its neighbors in the chain.
	typedef struct packed {
		sample_t value;
		age_t    age;
		logic    lt;      // held value is below the incoming sample
		logic    passed;  // the evicted cell sits at or before this one
	} smf_link_t;

	// Broadcast to every cell.
	typedef struct packed {
		logic    shift;       // a sample transfer happens this cycle
		sample_t x;           // the incoming sample
		logic    full;        // window holds its full length
		age_t    oldest_age;  // age of the sample to evict when full
	} smf_ctl_t;

	localparam smf_link_t LEFT_EDGE  = '{value: '0, age: '0, lt: 1'b1, passed: 1'b0};
	localparam smf_link_t RIGHT_EDGE = '{value: '0, age: '0, lt: 1'b0, passed: 1'b0};

endpackage

FILE: sv/smf_if.sv
// Stream interfaces of the sliding median filter: sample in, result out.
// Depends on smf_pkg.
interface smf_in_if
	import smf_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface smf_out_if
	import smf_pkg::*;
;
	logic    valid;
	logic    ready;
	sample_t median;
	count_t  fill_count;

	modport source (output valid, output median, output fill_count, input ready);
	modport sink (input valid, input median, input fill_count, output ready);
endinterface

FILE: sv/smf_cell.sv
// One cell of the sorted window chain: holds a sample and its age.
// Depends on smf_pkg; talks only to its left and right neighbors.
module smf_cell
	import smf_pkg::*;
(
	input  logic      clk,
	input  smf_ctl_t  ctl,
	input  logic      occupied,
	input  smf_link_t left_link,
	input  smf_link_t right_link,
	output smf_link_t link
);

	sample_t value_q;
	age_t    age_q;

	logic    lt;
	logic    evict_here;
	logic    passed;
	sample_t own_value;
	age_t    own_age;
	logic    own_lt;
	sample_t left_value;
	age_t    left_age;
	logic    left_lt;

	assign lt         = occupied && (value_q < ctl.x);
	assign evict_here = occupied && ctl.full && (age_q == ctl.oldest_age);
	assign passed     = evict_here || left_link.passed;

	assign link = '{value: value_q, age: age_q, lt: lt, passed: passed};

	// Close the gap left by the evicted sample, seen from this slot and its left.
	always_comb begin
		own_value  = passed ? right_link.value : value_q;
		own_age    = passed ? right_link.age : age_q;
		own_lt     = passed ? right_link.lt : lt;
		left_value = left_link.passed ? value_q : left_link.value;
		left_age   = left_link.passed ? age_q : left_link.age;
		left_lt    = left_link.passed ? lt : left_link.lt;
	end

	// Keep, take the new sample, or shift up from the left.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			if (own_lt) begin
				value_q <= own_value;
				age_q   <= own_age + 1'b1;
			end else if (left_lt) begin
				value_q <= ctl.x;
				age_q   <= '0;
			end else begin
				value_q <= left_value;
				age_q   <= left_age + 1'b1;
			end
		end
	end

endmodule

FILE: sv/smf_median.sv
// Median pick from the sorted chain and the registered result stage.
// Depends on smf_pkg and smf_out_if.
module smf_median
	import smf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  sample_t          values [WINDOW_MAX],
	input  count_t           count,
	input  logic             pending,
	output logic             slot_free,
	smf_out_if.source        result_ch
);

	logic    valid_q;
	sample_t median_q;
	count_t  fill_q;

	idx_t                   hi_idx;
	idx_t                   lo_idx;
	sample_t                hi_val;
	sample_t                lo_val;
	logic [SAMPLE_BITS:0]   pair_sum;
	sample_t                median_d;
	logic                   load;

	assign hi_idx   = IDX_BITS'(count >> 1);
	assign lo_idx   = hi_idx - 1'b1;
	assign hi_val   = values[hi_idx];
	assign lo_val   = values[lo_idx];
	assign pair_sum = {hi_val[SAMPLE_BITS-1], hi_val} + {lo_val[SAMPLE_BITS-1], lo_val};
	assign median_d = count[0] ? hi_val : pair_sum[SAMPLE_BITS:1];

	assign slot_free = !valid_q || result_ch.ready;
	assign load      = pending && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			median_q <= median_d;
			fill_q   <= count;
		end
	end

	assign result_ch.valid      = valid_q;
	assign result_ch.median     = median_q;
	assign result_ch.fill_count = fill_q;

endmodule

FILE: sv/sliding_median_filter_unit.sv
// Sliding median filter, one result per sample; it takes one sample per cycle unless a
// finished result is held behind a full result register.
// The sorted cell chain inserts the new sample and evicts the oldest in the transfer cycle;
// the median is then picked from the chain into the result register once that register is free.
// Reset (arst_n low, asynchronous) empties the window and sets the window length to 16.
// A write of window_len also empties the window.
module sliding_median_filter_unit
	import smf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  len_t       cfg_wdata,
	smf_in_if.sink     sample_ch,
	smf_out_if.source  result_ch
);

	// Configuration and fill state.
	len_t   window_len_q;
	count_t count_q;
	logic   valid_s1_q;   // chain holds a result not yet moved to the output

	count_t    eff_len;
	logic      full;
	logic      accept;
	logic      slot_free;
	smf_ctl_t  ctl;
	smf_link_t links [WINDOW_MAX];
	sample_t   values [WINDOW_MAX];

	// Clamp the length: zero acts as one, anything past the chain as the chain size.
	always_comb begin
		if (window_len_q == '0) begin
			eff_len = COUNT_BITS'(1);
		end else if (window_len_q > LEN_BITS'(WINDOW_MAX)) begin
			eff_len = COUNT_BITS'(WINDOW_MAX);
		end else begin
			eff_len = COUNT_BITS'(window_len_q);
		end
	end

	assign full = (count_q == eff_len);

	// Take a sample unless a finished result is stuck behind a full output register.
	assign sample_ch.ready = !valid_s1_q || slot_free;
	assign accept          = sample_ch.valid && sample_ch.ready;

	assign ctl = '{
		shift:      accept,
		x:          sample_ch.sample,
		full:       full,
		oldest_age: AGE_BITS'(eff_len - 1'b1)
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_BITS'(LEN_RESET);
			count_q      <= '0;
			valid_s1_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				// New length: drop every held sample.
				window_len_q <= cfg_wdata;
				count_q      <= '0;
			end else if (accept && !full) begin
				count_q <= count_q + 1'b1;
			end

			if (accept) begin
				valid_s1_q <= 1'b1;
			end else if (slot_free) begin
				valid_s1_q <= 1'b0;
			end
		end
	end

	// Sorted chain, ascending from cell 0; cells below count_q are occupied.
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		smf_link_t left_link;
		smf_link_t right_link;

		if (i == 0) begin : g_left_edge
			assign left_link = LEFT_EDGE;
		end else begin : g_left
			assign left_link = links[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_right_edge
			assign right_link = RIGHT_EDGE;
		end else begin : g_right
			assign right_link = links[i+1];
		end

		smf_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (COUNT_BITS'(i) < count_q),
			.left_link  (left_link),
			.right_link (right_link),
			.link       (links[i])
		);

		assign values[i] = links[i].value;
	end

	smf_median u_median (
		.clk       (clk),
		.arst_n    (arst_n),
		.values    (values),
		.count     (count_q),
		.pending   (valid_s1_q),
		.slot_free (slot_free),
		.result_ch (result_ch)
	);

`ifndef ASSERT_OFF
	a_count_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_len)
		else $error("fill count beyond window length");

	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> (result_ch.fill_count != '0))
		else $error("result from an empty window");

	a_transfer_pends: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1_q)
		else $error("sample transfer left no pending result");

	a_pending_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1_q && slot_free) |=> result_ch.valid)
		else $error("pending result not moved to output");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench of sliding_median_filter_unit: drives samples and window lengths through the
// stream and config ports and checks every result against a typed result or a running-median predictor.
// Depends on smf_pkg, smf_if and the filter unit itself.
module testbench;
	import smf_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 130;
	localparam int PHASE_COUNT  = 12;
	localparam int HOLD_AFTER   = 500;   // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES  = 300;
	localparam int REPORT_LIMIT = 10;

	// One result as the unit reports it.
	typedef struct packed {
		sample_t median;
		count_t  fill;
	} median_result_t;

	// Directed stimulus: either a sample transfer or a window length write.
	typedef enum logic [0:0] {ROW_SAMPLE, ROW_SET_LEN} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [15:0] value;       // sample, or the window length in the low bits
		logic        has_result;  // expected result typed in below
		sample_t     median;
		count_t      fill;
	} directed_row_t;

	// Extremes, the 17-bit pair sum, the zero and oversize window lengths and the
	// emptying on a length write. Rows without a typed result go to the predictor.
	localparam directed_row_t DIRECTED_ROWS [25] = '{
		'{ROW_SAMPLE,  16'h7fff, 1'b1, 16'h7fff, 5'd1},
		'{ROW_SAMPLE,  16'h8000, 1'b1, 16'hffff, 5'd2},
		'{ROW_SAMPLE,  16'h0000, 1'b1, 16'h0000, 5'd3},
		'{ROW_SAMPLE,  16'hffff, 1'b1, 16'hffff, 5'd4},
		'{ROW_SET_LEN, 16'd0,    1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'h8000, 1'b1, 16'h8000, 5'd1},
		'{ROW_SAMPLE,  16'h3039, 1'b1, 16'h3039, 5'd1},
		'{ROW_SET_LEN, 16'd2,    1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'h0064, 1'b1, 16'h0064, 5'd1},
		'{ROW_SAMPLE,  16'hff9b, 1'b1, 16'hffff, 5'd2},
		'{ROW_SAMPLE,  16'h0007, 1'b1, 16'hffd1, 5'd2},
		'{ROW_SET_LEN, 16'd31,   1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'hfffb, 1'b1, 16'hfffb, 5'd1},
		'{ROW_SAMPLE,  16'h0005, 1'b1, 16'h0000, 5'd2},
		'{ROW_SAMPLE,  16'h5555, 1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'haaaa, 1'b0, 16'h0000, 5'd0},
		'{ROW_SET_LEN, 16'd3,    1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'h8000, 1'b1, 16'h8000, 5'd1},
		'{ROW_SAMPLE,  16'h8000, 1'b1, 16'h8000, 5'd2},
		'{ROW_SAMPLE,  16'h7fff, 1'b1, 16'h8000, 5'd3},
		'{ROW_SAMPLE,  16'h7fff, 1'b1, 16'h7fff, 5'd3},
		'{ROW_SET_LEN, 16'd16,   1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'h0003, 1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'hfffe, 1'b0, 16'h0000, 5'd0},
		'{ROW_SAMPLE,  16'h0009, 1'b0, 16'h0000, 5'd0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	len_t cfg_wdata;

	smf_in_if  sample_ch ();
	smf_out_if result_ch ();

	sliding_median_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	// Predictor state: circular sample history, oldest slot, count held, length setting.
	sample_t     window_hist [WINDOW_MAX];
	int unsigned oldest_ix;
	int unsigned held_n;
	len_t        window_setting;

	median_result_t pending_medians [$];
	int unsigned    mismatch_count;
	int unsigned    results_seen;
	int unsigned    cycle_count;
	logic           steady;     // no idling on either side while set
	logic           hold_done;
	sample_t        ramp_value;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Insert one sample into the predicted window and return the median and fill.
	function automatic median_result_t windowed_median(input sample_t s);
		int unsigned span;
		int unsigned i;
		int unsigned j;
		sample_t ordered [WINDOW_MAX];
		sample_t v;
		logic signed [SAMPLE_BITS:0] pair_sum;
		logic signed [SAMPLE_BITS:0] halved;
		median_result_t r;
		// A zero length acts as one; anything above the store size saturates.
		span = (window_setting == 0) ? 1 :
			((window_setting > WINDOW_MAX) ? WINDOW_MAX : int'(window_setting));
		if (held_n > span)
			held_n = span;
		if (oldest_ix >= span)
			oldest_ix = 0;
		// Full window: drop the oldest before the new sample goes in.
		if (held_n == span) begin
			oldest_ix = (oldest_ix + 1) % span;
			held_n--;
		end
		window_hist[(oldest_ix + held_n) % span] = s;
		held_n++;
		for (i = 0; i < held_n; i++) begin
			v = window_hist[(oldest_ix + i) % span];
			j = i;
			while (j > 0 && ordered[j-1] > v) begin
				ordered[j] = ordered[j-1];
				j--;
			end
			ordered[j] = v;
		end
		if (held_n % 2 == 1) begin
			r.median = ordered[held_n / 2];
		end else begin
			// Sum one bit wider than a sample, then floor-halve it.
			pair_sum = ordered[held_n / 2] + ordered[held_n / 2 - 1];
			halved   = pair_sum >>> 1;
			r.median = halved[SAMPLE_BITS-1:0];
		end
		r.fill = count_t'(held_n);
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int unsigned pick_stall();
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Mix of full-range noise, a narrow band with many ties, the rails and a ramp.
	function automatic sample_t pick_sample();
		int band;
		case ($urandom_range(0, 7))
			0, 1, 2: return sample_t'($urandom);
			3, 4: begin
				band = int'($urandom_range(0, 16)) - 8;
				return sample_t'(band);
			end
			5: begin
				case ($urandom_range(0, 3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'hffff;
					default: return 16'h0000;
				endcase
			end
			6: return $urandom_range(0, 1) ? sample_t'(16'h7fff - $urandom_range(0, 3)) :
				sample_t'(16'h8000 + $urandom_range(0, 3));
			default: begin
				ramp_value = ramp_value + sample_t'($urandom_range(0, 600)) - 16'sd300;
				return ramp_value;
			end
		endcase
	endfunction

	// Offer one sample after a random gap and hold it until the transfer.
	task automatic send_sample(input sample_t s, input logic typed,
			input median_result_t typed_result);
		int unsigned gap;
		median_result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do @(posedge clk); while (!sample_ch.ready);
		// Advance the predictor on the transfer; a typed row supplies its own result.
		predicted = windowed_median(s);
		pending_medians.push_back(typed ? typed_result : predicted);
	endtask

	// Write the window length only once every pending result has drained.
	task automatic set_window_len(input len_t len);
		sample_ch.valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we         <= 1'b0;
		window_setting = len;
		oldest_ix      = 0;
		held_n         = 0;
	endtask

	// Stimulus: reset, the directed table, then random phases over several lengths.
	initial begin : stimulus
		len_t phase_lens [PHASE_COUNT];
		median_result_t typed_result;
		int p;
		int n;
		phase_lens = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd7, 5'd4,
			5'd15, 5'd16, 5'd3, 5'd9};
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		steady         = 1'b0;
		hold_done      = 1'b0;
		ramp_value     = '0;
		mismatch_count = 0;
		results_seen   = 0;
		window_setting = len_t'(LEN_RESET);
		oldest_ix      = 0;
		held_n         = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[k]) begin
			if (DIRECTED_ROWS[k].kind == ROW_SET_LEN) begin
				set_window_len(len_t'(DIRECTED_ROWS[k].value));
			end else begin
				typed_result.median = DIRECTED_ROWS[k].median;
				typed_result.fill   = DIRECTED_ROWS[k].fill;
				send_sample(sample_t'(DIRECTED_ROWS[k].value), DIRECTED_ROWS[k].has_result,
					typed_result);
			end
		end

		// Past the fixed lengths, draw random ones over the whole 5-bit range.
		for (p = 0; p < PHASE_COUNT; p++) begin
			if (p >= 8)
				phase_lens[p] = len_t'($urandom_range(0, 31));
			set_window_len(phase_lens[p]);
			steady = (p == 2 || p == 9);
			for (n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_sample(), 1'b0, typed_result);
		end
		steady = 1'b0;
		sample_ch.valid <= 1'b0;

		// Drain, then keep watching the result register for any stray result before the verdict.
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_medians.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off so the unit backs up.
	initial begin : result_drain
		int unsigned stall;
		result_ch.ready <= 1'b0;
		stall = 0;
		forever begin
			@(posedge clk);
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				stall     = HOLD_CYCLES;
			end else if (stall == 0) begin
				stall = pick_stall();
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest pending expectation.
	always @(posedge clk) begin : check_results
		median_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (pending_medians.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("%0t: unexpected result median=%0d fill=%0d", $realtime,
						result_ch.median, result_ch.fill_count);
				mismatch_count++;
			end else begin
				want = pending_medians.pop_front();
				if (result_ch.median !== want.median || result_ch.fill_count !== want.fill) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: median %0d fill %0d, expected median %0d fill %0d",
							$realtime, result_ch.median, result_ch.fill_count,
							want.median, want.fill);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

endmodule
